@@ design/rational_arith_gcd_reduce_unit_defines.svh @@
`ifndef RATIONAL_ARITH_GCD_REDUCE_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_GCD_REDUCE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RGR_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("rgr assertion failed");

// next-cycle implication, checked outside reset
`define RGR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("rgr assertion failed");

`endif

@@ design/rgr_pkg.sv @@
`default_nettype none

package rgr_pkg;

  // input fraction field width
  localparam int IN_WIDTH = 16;
  // product width and signed working width of sums and magnitudes
  localparam int PW       = 2 * IN_WIDTH;
  localparam int MW       = PW + 1;
  // result field width and extension width for sign application
  localparam int OW       = 32;
  localparam int XW       = 64;
  // gcd shift counter and divider step counter widths
  localparam int KW       = $clog2(MW + 1);
  localparam int CW       = $clog2(MW);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } rgr_cmd_e;

  typedef enum logic [1:0] {
    MSEL_N0 = 2'd0,
    MSEL_N1 = 2'd1,
    MSEL_D  = 2'd2
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_PREP,
    S_GCD,
    S_DIV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     n_load;
    logic     n_acc;
    logic     d_load;
    logic     prep;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     res_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/rgr_chan_if.sv @@
`default_nettype none

// operand channel
interface rgr_in_if;
  import rgr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic signed [IN_WIDTH-1:0] num_a;
  logic signed [IN_WIDTH-1:0] den_a;
  logic signed [IN_WIDTH-1:0] num_b;
  logic signed [IN_WIDTH-1:0] den_b;

  modport source (output valid, command, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, command, num_a, den_a, num_b, den_b, output ready);
endinterface

// result channel
interface rgr_out_if;
  import rgr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] num_out;
  logic signed [OW-1:0] den_out;
  logic                 zero_den;

  modport source (output valid, num_out, den_out, zero_den, input ready);
  modport sink   (input valid, num_out, den_out, zero_den, output ready);
endinterface

`default_nettype wire

@@ design/rgr_ctrl.sv @@
`default_nettype none

`include "rational_arith_gcd_reduce_unit_defines.svh"

module rgr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  input  wire rgr_pkg::dp_status_t status_i,
  output rgr_pkg::ctrl_cmd_t      cmd_o
);
  import rgr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_PREP;
      S_PREP: state_d = status_i.special ? S_FIN : S_GCD;
      S_GCD:  if (status_i.gcd_done) state_d = S_DIV;
      S_DIV:  if (status_i.div_last) state_d = S_FIN;
      S_FIN:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MSEL_N0;
      end
      S_MUL1: begin
        cmd_o.n_load  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MSEL_N1;
      end
      S_MUL2: begin
        cmd_o.n_acc   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MSEL_D;
      end
      S_MUL3: cmd_o.d_load = 1'b1;
      S_PREP: cmd_o.prep = 1'b1;
      S_GCD: begin
        cmd_o.div_init = status_i.gcd_done;
        cmd_o.gcd_step = !status_i.gcd_done;
      end
      S_DIV:  cmd_o.div_step = 1'b1;
      S_FIN:  cmd_o.res_write = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  // result valid: set on write, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_write) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `RGR_ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, cmd_o.res_write, !out_valid_q || out_ready_i)
  `RGR_ASSERT_IMPLIES(a_gcd_live, clk_i, rst_ni, cmd_o.gcd_step, !status_i.gcd_done)
  `RGR_ASSERT_NEXT(a_div_follows_init, clk_i, rst_ni, cmd_o.div_init, state_q == S_DIV)
  `RGR_ASSERT_NEXT(a_load_starts_mul, clk_i, rst_ni, cmd_o.load, state_q == S_MUL0)

endmodule

`default_nettype wire

@@ design/rgr_datapath.sv @@
`default_nettype none

module rgr_datapath (
  input  wire logic                                clk_i,
  input  wire rgr_pkg::ctrl_cmd_t                  cmd_i,
  input  wire logic [1:0]                          command_i,
  input  wire logic signed [rgr_pkg::IN_WIDTH-1:0] num_a_i,
  input  wire logic signed [rgr_pkg::IN_WIDTH-1:0] den_a_i,
  input  wire logic signed [rgr_pkg::IN_WIDTH-1:0] num_b_i,
  input  wire logic signed [rgr_pkg::IN_WIDTH-1:0] den_b_i,
  output rgr_pkg::dp_status_t                      status_o,
  output logic signed [rgr_pkg::OW-1:0]            num_out_o,
  output logic signed [rgr_pkg::OW-1:0]            den_out_o,
  output logic                                     zero_den_o
);
  import rgr_pkg::*;

  // apply a sign to a magnitude and keep the low result bits
  function automatic logic [OW-1:0] apply_sign(input logic neg, input logic [MW-1:0] mag);
    logic [XW-1:0] x;
    x = {{(XW-MW){1'b0}}, mag};
    if (neg) x = -x;
    return x[OW-1:0];
  endfunction

  rgr_cmd_e                   op_q;
  logic signed [IN_WIDTH-1:0] na_q, da_q, nb_q, db_q;
  logic signed [IN_WIDTH-1:0] mul_a, mul_b;
  logic signed [PW-1:0]       prod_d, prod_q;
  logic signed [MW-1:0]       n_q, d_ext;
  logic signed [PW-1:0]       d_q;
  logic                       n_neg_raw, d_neg_raw;
  logic                       nneg_q, dneg_q, spec_q, spec_zd_q;
  logic [MW-1:0]              nm_q, dm_q, u_q, v_q, g_q;
  logic [KW-1:0]              k_q;
  logic [MW:0]                rn_q, rd_q, trial_n, trial_d;
  logic [MW-1:0]              qn_q, qd_q;
  logic [CW-1:0]              cnt_q;
  logic                       bit_n, bit_d;
  logic signed [OW-1:0]       num_q, den_q;
  logic                       zd_q;

  // multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      MSEL_N0: begin
        mul_a = na_q;
        mul_b = (op_q == CMD_MUL) ? nb_q : db_q;
      end
      MSEL_N1: begin
        mul_a = nb_q;
        mul_b = da_q;
      end
      MSEL_D: begin
        mul_a = da_q;
        mul_b = (op_q == CMD_DIV) ? nb_q : db_q;
      end
      default: begin
        mul_a = na_q;
        mul_b = db_q;
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // operand capture, product register and cross-term accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= rgr_cmd_e'(command_i);
      na_q <= num_a_i;
      da_q <= den_a_i;
      nb_q <= num_b_i;
      db_q <= den_b_i;
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.n_load) n_q <= MW'(prod_q);
    if (cmd_i.n_acc) begin
      case (op_q)
        CMD_ADD: n_q <= n_q + MW'(prod_q);
        CMD_SUB: n_q <= n_q - MW'(prod_q);
        default: n_q <= n_q;
      endcase
    end
    if (cmd_i.d_load) d_q <= prod_q;
  end

  // sign and special-case decode
  assign d_ext     = MW'(d_q);
  assign n_neg_raw = n_q[MW-1];
  assign d_neg_raw = d_q[PW-1];

  assign status_o.special  = (d_q == '0) || (n_q == '0);
  assign status_o.gcd_done = (u_q == '0) || (v_q == '0);
  assign status_o.div_last = (cnt_q == CW'(MW - 1));

  // restoring divider trial subtraction, two lanes sharing the gcd
  assign trial_n = {rn_q[MW-1:0], qn_q[MW-1]};
  assign trial_d = {rd_q[MW-1:0], qd_q[MW-1]};
  assign bit_n   = (trial_n >= {1'b0, g_q});
  assign bit_d   = (trial_d >= {1'b0, g_q});

  // magnitudes, binary gcd and division
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      nneg_q    <= n_neg_raw && !d_neg_raw;
      dneg_q    <= d_neg_raw && !n_neg_raw;
      spec_q    <= (d_q == '0) || (n_q == '0);
      spec_zd_q <= (d_q == '0);
      nm_q      <= n_neg_raw ? -n_q : n_q;
      dm_q      <= d_neg_raw ? -d_ext : d_ext;
      u_q       <= n_neg_raw ? -n_q : n_q;
      v_q       <= d_neg_raw ? -d_ext : d_ext;
      k_q       <= '0;
    end
    if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= (u_q - v_q) >> 1;
      end else begin
        v_q <= (v_q - u_q) >> 1;
      end
    end
    if (cmd_i.div_init) begin
      g_q   <= (u_q | v_q) << k_q;
      rn_q  <= '0;
      rd_q  <= '0;
      qn_q  <= nm_q;
      qd_q  <= dm_q;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rn_q  <= bit_n ? (trial_n - {1'b0, g_q}) : trial_n;
      rd_q  <= bit_d ? (trial_d - {1'b0, g_q}) : trial_d;
      qn_q  <= {qn_q[MW-2:0], bit_n};
      qd_q  <= {qd_q[MW-2:0], bit_d};
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_write) begin
      zd_q <= spec_zd_q;
      if (spec_q) begin
        num_q <= '0;
        den_q <= spec_zd_q ? '0 : apply_sign(dneg_q, MW'(1));
      end else begin
        num_q <= apply_sign(nneg_q, qn_q);
        den_q <= apply_sign(dneg_q, qd_q);
      end
    end
  end

  assign num_out_o  = num_q;
  assign den_out_o  = den_q;
  assign zero_den_o = zd_q;

endmodule

`default_nettype wire

@@ design/rational_arith_gcd_reduce_unit.sv @@
// Rational arithmetic unit with gcd reduction.
// in_i carries a command (add, subtract, multiply, divide) and two signed
// fractions num_a/den_a and num_b/den_b; out_o carries the reduced result
// num_out/den_out and zero_den. Both channels transfer on valid && ready.
// One item is worked on at a time: the three products come in turn from one
// shared multiplier, then a binary gcd runs one step a cycle, then a
// restoring divider reduces numerator and denominator together, one quotient
// bit a cycle, MW (33) bits in all. A zero numerator or zero denominator
// skips the gcd and the divider. With a result taken at once the next item
// is accepted in the cycle after the result is written.
// A finished result waits in an output register; a new item is accepted
// while it waits, and the next result is held back until it is taken.
// Reset clears the controller and drops any pending result.
`default_nettype none

module rational_arith_gcd_reduce_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rgr_in_if.sink     in_i,
  rgr_out_if.source  out_o
);
  import rgr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing controller
  rgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic datapath
  rgr_datapath u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .command_i  (in_i.command),
    .num_a_i    (in_i.num_a),
    .den_a_i    (in_i.den_a),
    .num_b_i    (in_i.num_b),
    .den_b_i    (in_i.den_b),
    .status_o   (status),
    .num_out_o  (out_o.num_out),
    .den_out_o  (out_o.den_out),
    .zero_den_o (out_o.zero_den)
  );

endmodule

`default_nettype wire

@@ bench/tb_rational_arith_gcd_reduce_unit.sv @@
`default_nettype none

module tb_rational_arith_gcd_reduce_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rgr_pkg::*;

  localparam int OP_MAX      = 2 ** (IN_WIDTH - 1) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 150;

  typedef logic signed [IN_WIDTH-1:0] operand_t;

  // one reduced fraction as it leaves the block
  typedef struct packed {
    logic signed [OW-1:0] num;
    logic signed [OW-1:0] den;
    logic                 zero_den;
  } fraction_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rgr_in_if  op_if ();
  rgr_out_if res_if ();

  rational_arith_gcd_reduce_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (res_if)
  );

  fraction_t pending_fracs[$];
  fraction_t got_frac;
  fraction_t want_frac;
  int        err_cnt;
  int        cycle_cnt;
  int        src_idle_pct;
  int        snk_idle_pct;
  int        op_cnt[4];
  int        zero_den_cnt;
  int        zero_num_cnt;
  int        checked_cnt;

  // clock, 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected reduced fraction for one operand transfer
  function automatic fraction_t reduce_rational(rgr_cmd_e cmd, operand_t na, operand_t da,
                                                operand_t nb, operand_t db);
    longint          a_n, a_d, b_n, b_d;
    longint          n, d;
    longint unsigned nm, dm, g, x, t;
    logic            nneg, dneg;
    fraction_t       r;
    a_n = na;
    a_d = da;
    b_n = nb;
    b_d = db;
    case (cmd)
      CMD_ADD: begin
        n = a_n * b_d + b_n * a_d;
        d = a_d * b_d;
      end
      CMD_SUB: begin
        n = a_n * b_d - b_n * a_d;
        d = a_d * b_d;
      end
      CMD_MUL: begin
        n = a_n * b_n;
        d = a_d * b_d;
      end
      default: begin
        n = a_n * b_d;
        d = a_d * b_n;
      end
    endcase
    r = '0;
    if (d == 0) begin
      r.zero_den = 1'b1;
      return r;
    end
    nneg = (n < 0);
    dneg = (d < 0);
    // two negative signs cancel, mixed signs stay
    if (nneg && dneg) begin
      nneg = 1'b0;
      dneg = 1'b0;
    end
    nm = (n < 0) ? longint'(-n) : n;
    dm = (d < 0) ? longint'(-d) : d;
    if (nm == 0) begin
      r.den = dneg ? -1 : 1;
      return r;
    end
    // euclid over magnitudes
    g = nm;
    x = dm;
    while (x != 0) begin
      t = g % x;
      g = x;
      x = t;
    end
    nm = nm / g;
    dm = dm / g;
    r.num = OW'(nneg ? (64'd0 - nm) : nm);
    r.den = OW'(dneg ? (64'd0 - dm) : dm);
    return r;
  endfunction

  // operand values weighted toward zero, unit, extremes and common factors
  function automatic operand_t pick_operand();
    int v;
    case ($urandom_range(15))
      0:       v = 0;
      1:       v = 1;
      2:       v = -1;
      3:       v = OP_MAX;
      4:       v = -OP_MAX;
      5, 6, 7: v = int'($urandom_range(24)) - 12;
      8, 9:    v = (int'($urandom_range(60)) - 30) * (int'($urandom_range(999)) + 1);
      default: v = int'($urandom_range(2 * OP_MAX)) - OP_MAX;
    endcase
    return v[IN_WIDTH-1:0];
  endfunction

  // result side backpressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // compare each result transfer against the oldest expected fraction
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_frac = '{num: res_if.num_out, den: res_if.den_out, zero_den: res_if.zero_den};
      if (pending_fracs.size() == 0) begin
        $error("result with nothing expected: num_out %0d den_out %0d zero_den %0b",
               got_frac.num, got_frac.den, got_frac.zero_den);
        err_cnt++;
      end else begin
        want_frac = pending_fracs.pop_front();
        checked_cnt++;
        if (got_frac.num !== want_frac.num) begin
          $error("num_out: expected %0d, got %0d", want_frac.num, got_frac.num);
          err_cnt++;
        end
        if (got_frac.den !== want_frac.den) begin
          $error("den_out: expected %0d, got %0d", want_frac.den, got_frac.den);
          err_cnt++;
        end
        if (got_frac.zero_den !== want_frac.zero_den) begin
          $error("zero_den: expected %0b, got %0b", want_frac.zero_den, got_frac.zero_den);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_fracs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one operand transfer; entered and left just after a falling edge
  task automatic push_operands(rgr_cmd_e cmd, operand_t na, operand_t da,
                               operand_t nb, operand_t db);
    fraction_t f;
    while ($urandom_range(99) < src_idle_pct) begin
      op_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    op_if.valid   <= 1'b1;
    op_if.command <= cmd;
    op_if.num_a   <= na;
    op_if.den_a   <= da;
    op_if.num_b   <= nb;
    op_if.den_b   <= db;
    do @(posedge clk_i); while (!op_if.ready);
    f = reduce_rational(cmd, na, da, nb, db);
    pending_fracs.push_back(f);
    op_cnt[cmd]++;
    if (f.zero_den) zero_den_cnt++;
    else if (f.num == 0) zero_num_cnt++;
    @(negedge clk_i);
  endtask

  // hand-picked corners: extremes, signs, zero numerator, zero denominator
  task automatic test_directed_corners();
    push_operands(CMD_ADD, 1, 2, 1, 3);
    push_operands(CMD_SUB, 1, 2, 1, 2);
    push_operands(CMD_MUL, OP_MAX, OP_MAX, -OP_MAX, OP_MAX);
    push_operands(CMD_DIV, OP_MAX, -OP_MAX, -OP_MAX, OP_MAX);
    push_operands(CMD_ADD, -OP_MAX, -OP_MAX, -OP_MAX, -OP_MAX);
    push_operands(CMD_ADD, OP_MAX, 1, OP_MAX, 1);
    push_operands(CMD_SUB, OP_MAX, 1, -OP_MAX, 1);
    push_operands(CMD_MUL, -OP_MAX, -1, -OP_MAX, -1);
    push_operands(CMD_DIV, 1, -OP_MAX, OP_MAX, 1);
    push_operands(CMD_DIV, OP_MAX, OP_MAX - 1, OP_MAX - 1, OP_MAX);
    // zero denominator
    push_operands(CMD_ADD, 1, 0, 1, 2);
    push_operands(CMD_DIV, 3, 4, 0, 5);
    push_operands(CMD_ADD, 0, 0, 0, 0);
    push_operands(CMD_SUB, 0, 0, 0, 0);
    push_operands(CMD_MUL, 0, 0, 0, 0);
    push_operands(CMD_DIV, 0, 0, 0, 0);
    // zero numerator, both denominator signs
    push_operands(CMD_MUL, 0, -3, 5, 7);
    push_operands(CMD_SUB, 0, 5, 0, -7);
    push_operands(CMD_MUL, 0, 3, 5, 7);
    // both negative, then mixed signs
    push_operands(CMD_MUL, -2, 3, 4, -5);
    push_operands(CMD_MUL, -2, 3, 4, 5);
    push_operands(CMD_MUL, 2, 3, 4, -5);
    // heavy common factors
    push_operands(CMD_ADD, 6, 8, 10, 12);
    push_operands(CMD_DIV, 1024, -4096, -2048, 512);
  endtask

  // random commands and operands
  task automatic test_random_mix(int n_items);
    repeat (n_items) begin
      push_operands(rgr_cmd_e'($urandom_range(3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand());
    end
  endtask

  // bursts separated by a full drain of the unit
  task automatic test_drained_restart();
    repeat (4) begin
      test_random_mix(6);
      op_if.valid <= 1'b0;
      wait (pending_fracs.size() == 0);
      @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    op_if.valid   = 1'b0;
    op_if.command = CMD_ADD;
    op_if.num_a   = '0;
    op_if.den_a   = '0;
    op_if.num_b   = '0;
    op_if.den_b   = '0;
    src_idle_pct  = 25;
    snk_idle_pct  = 87;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender mostly busy, receiver mostly stalled
    test_directed_corners();
    test_random_mix(400);
    test_drained_restart();

    // sender mostly idle, receiver mostly ready
    src_idle_pct = 87;
    snk_idle_pct = 25;
    test_random_mix(440);

    // no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_mix(460);
    op_if.valid <= 1'b0;

    wait (pending_fracs.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d results: add %0d, sub %0d, mul %0d, div %0d", checked_cnt,
             op_cnt[CMD_ADD], op_cnt[CMD_SUB], op_cnt[CMD_MUL], op_cnt[CMD_DIV]);
    $display("%0d zero denominators, %0d zero numerators, three idle profiles, %0d cycles",
             zero_den_cnt, zero_num_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
